>>> src/btkq_pkg.sv
// package: payload types, cell interface types and constants of the top-k queue
`timescale 1ns / 1ps
package btkq_pkg;

	localparam int KEY_W     = 32;
	localparam int TAG_W     = 16;
	localparam int OCC_W     = 6;
	localparam int CAP_W     = 6;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int DEPTH_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

	localparam logic [CAP_W-1:0] CAPACITY_RST = 6'd32;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef struct packed {
		logic                    kind;
		logic signed [KEY_W-1:0] entry_key;
		logic [TAG_W-1:0]        entry_tag;
	} in_item_t;

	typedef struct packed {
		logic                    stored;
		logic                    evicted;
		logic                    pop_valid;
		logic signed [KEY_W-1:0] out_key;
		logic [TAG_W-1:0]        out_tag;
		logic [OCC_W-1:0]        occupancy;
	} out_item_t;

	// one queue slot as it moves between neighboring cells
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} entry_t;

	// command broadcast to every cell
	typedef struct packed {
		logic                    insert;
		logic                    pop;
		logic                    grow;
		logic signed [KEY_W-1:0] key;
		logic [TAG_W-1:0]        tag;
	} cell_ctl_t;

endpackage

>>> src/bounded_top_k_queue_unit.sv
// top level: bounded top-k priority queue built as a chain of sorting cells
`timescale 1ns / 1ps
// usage
//   in channel (in_valid, in_stall, in_data): kind selects insert or pop of the largest entry
//   out channel (out_valid, out_stall, out_data): exactly one result per input transfer
//   config port (cfg_wr_en, cfg_index, cfg_wdata): capacity, threshold enable, threshold;
//     write only while the queue is idle, unknown indexes are ignored
// timing and throughput
//   a result appears in the cycle after its input transfer; while the receiver does
//   not stall, one item per cycle is sustained, since every cell compares against the
//   broadcast key in parallel and shifts with its neighbor in the same cycle
// stalls
//   the result register holds while out_stall is high; in_stall rises only while a
//   result waits and the receiver stalls, so a new transfer is taken in the cycle
//   the old result leaves
// reset
//   arst_n clears all slot valid bits, the fill count and the result valid, and
//   loads capacity 32, threshold disabled, threshold 0; slot payloads are not reset
module bounded_top_k_queue_unit
	import btkq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

	// configuration registers
	logic [CAP_W-1:0]        capacity_q;
	logic                    thr_en_q;
	logic signed [KEY_W-1:0] threshold_q;

	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_d;

	out_item_t res_q;
	logic      out_valid_q;

	cell_ctl_t ctl;
	entry_t    slots [DEPTH];
	logic      gt    [DEPTH];
	logic      ge    [DEPTH];
	logic [DEPTH-1:0] beats_last;

	logic accept;
	logic is_pop;
	logic full;
	logic above_last;
	logic above_thr;
	logic ins_take;
	logic pop_hit;

	assign in_stall  = out_valid_q && out_stall;
	assign accept    = in_valid && !in_stall;
	assign is_pop    = (in_data.kind == KIND_POP);
	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	// full when fill reaches the capacity, which saturates at the chain length
	assign full = (CMP_W'(fill_q) >= CMP_W'(capacity_q)) || (fill_q == FILL_W'(DEPTH));

	// the new key beats the smallest entry when the last valid cell holds a lower key
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == DEPTH - 1) begin
				beats_last[i] = slots[i].valid && !ge[i];
			end else begin
				beats_last[i] = slots[i].valid && !slots[i+1].valid && !ge[i];
			end
		end
	end
	assign above_last = |beats_last;
	assign above_thr  = !thr_en_q || (in_data.entry_key > threshold_q);
	assign ins_take   = !full || (above_last && above_thr);
	assign pop_hit    = (fill_q != '0);

	always_comb begin
		ctl.insert = accept && !is_pop && ins_take;
		ctl.pop    = accept && is_pop && pop_hit;
		ctl.grow   = !full;
		ctl.key    = in_data.entry_key;
		ctl.tag    = in_data.entry_tag;
	end

	// the chain: cell 0 holds the largest key, data shifts right on insert, left on pop
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t left_ent;
		entry_t right_ent;
		logic   left_gt;
		if (g == 0) begin : g_head
			assign left_ent = '0;
			assign left_gt  = 1'b1;
		end else begin : g_body
			assign left_ent = slots[g-1];
			assign left_gt  = gt[g-1];
		end
		if (g == DEPTH - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_next
			assign right_ent = slots[g+1];
		end
		btkq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.left    (left_ent),
			.left_gt (left_gt),
			.right   (right_ent),
			.slot    (slots[g]),
			.gt      (gt[g]),
			.ge      (ge[g])
		);
	end

	always_comb begin
		fill_d = fill_q;
		if (ctl.insert && ctl.grow) begin
			fill_d = fill_q + FILL_W'(1);
		end else if (ctl.pop) begin
			fill_d = fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAPACITY_RST;
			thr_en_q    <= 1'b0;
			threshold_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_CAPACITY:  capacity_q  <= cfg_wdata[CAP_W-1:0];
				CFG_THR_EN:    thr_en_q    <= cfg_wdata[0];
				CFG_THRESHOLD: threshold_q <= $signed(cfg_wdata[KEY_W-1:0]);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			fill_q <= fill_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, loaded on every input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.stored    <= !is_pop && ins_take;
			res_q.evicted   <= !is_pop && ins_take && full;
			res_q.pop_valid <= is_pop && pop_hit;
			res_q.out_key   <= (is_pop && pop_hit) ? slots[0].key : '0;
			res_q.out_tag   <= (is_pop && pop_hit) ? slots[0].tag : '0;
			res_q.occupancy <= OCC_W'(fill_d);
		end
	end

endmodule

>>> src/btkq_cell.sv
// one slot of the sorted queue with its local compare and neighbor shift
`timescale 1ns / 1ps
module btkq_cell
	import btkq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    left,
	input  logic      left_gt,
	input  entry_t    right,
	output entry_t    slot,
	output logic      gt,
	output logic      ge
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic [TAG_W-1:0]        tag_q;
	entry_t                  slot_cur;
	entry_t                  slot_d;

	assign slot_cur.valid = valid_q;
	assign slot_cur.key   = key_q;
	assign slot_cur.tag   = tag_q;

	assign slot = slot_cur;
	assign gt   = slot_cur.valid && (slot_cur.key > ctl.key);
	assign ge   = slot_cur.valid && (slot_cur.key >= ctl.key);

	always_comb begin
		slot_d = slot_cur;
		if (ctl.pop) begin
			slot_d = right;
		end else if (ctl.insert && !gt) begin
			// first cell not above the new key takes it, later cells shift down
			if (left_gt) begin
				slot_d.key = ctl.key;
				slot_d.tag = ctl.tag;
				slot_d.valid = ctl.grow ? 1'b1 : slot_cur.valid;
			end else begin
				slot_d.key = left.key;
				slot_d.tag = left.tag;
				slot_d.valid = ctl.grow ? left.valid : slot_cur.valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= slot_d.key;
		tag_q <= slot_d.tag;
	end

endmodule

>>> verif/topk_queue_checker.sv
// checker: predicts each result of the top-k queue and compares it with the block
`timescale 1ns / 1ps
module topk_queue_checker
	import btkq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_item_t            out_data,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output int                   fail_count,
	output int                   pending
);

	// ranked copy of the queue, slot 0 holds the largest key
	logic signed [KEY_W-1:0] ranked_key [DEPTH_DEF];
	logic [TAG_W-1:0]        ranked_tag [DEPTH_DEF];
	int                      held = 0;

	logic [CAP_W-1:0]        cap_now = CAPACITY_RST;
	logic                    thr_on  = 1'b0;
	logic signed [KEY_W-1:0] thr_key = '0;

	out_item_t due_results [$];
	int        mismatch_total = 0;
	int        waiting = 0;
	int        results_seen = 0;

	assign fail_count = mismatch_total;
	assign pending    = waiting;

	// applies one item to the queue copy and returns the result it must produce
	function automatic out_item_t apply_item(input in_item_t item);
		out_item_t res;
		int        limit;
		int        pos;
		int        last;
		int        i;
		bit        full;
		res = '0;
		limit = (cap_now > DEPTH_DEF) ? DEPTH_DEF : int'(cap_now);
		if (item.kind == KIND_POP) begin
			if (held > 0) begin
				res.pop_valid = 1'b1;
				res.out_key   = ranked_key[0];
				res.out_tag   = ranked_tag[0];
				for (i = 0; i + 1 < held; i++) begin
					ranked_key[i] = ranked_key[i + 1];
					ranked_tag[i] = ranked_tag[i + 1];
				end
				held--;
			end
		end else begin
			full = (held >= limit);
			if (!full || (held > 0 && item.entry_key > ranked_key[held - 1] &&
					(!thr_on || item.entry_key > thr_key))) begin
				res.stored  = 1'b1;
				res.evicted = full;
				pos = 0;
				while (pos < held && ranked_key[pos] > item.entry_key)
					pos++;
				last = full ? held - 1 : held;
				for (i = last; i > pos; i--) begin
					ranked_key[i] = ranked_key[i - 1];
					ranked_tag[i] = ranked_tag[i - 1];
				end
				ranked_key[pos] = item.entry_key;
				ranked_tag[pos] = item.entry_tag;
				if (!full)
					held++;
			end
		end
		res.occupancy = held[OCC_W-1:0];
		return res;
	endfunction

	always @(posedge clk) begin : watch
		out_item_t want;
		if (!arst_n) begin
			held    = 0;
			cap_now = CAPACITY_RST;
			thr_on  = 1'b0;
			thr_key = '0;
		end else begin
			// results first: each one belongs to an earlier input transfer
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_results.size() == 0) begin
					if (mismatch_total < 10)
						$display("%t: result %0d arrived with nothing expected",
							$time, results_seen);
					mismatch_total++;
				end else begin
					want = due_results.pop_front();
					if (want.stored !== out_data.stored || want.evicted !== out_data.evicted ||
							want.pop_valid !== out_data.pop_valid ||
							want.out_key !== out_data.out_key ||
							want.out_tag !== out_data.out_tag ||
							want.occupancy !== out_data.occupancy) begin
						if (mismatch_total < 10)
							$display({"%t: result %0d mismatch: expected st=%0b ev=%0b pv=%0b ",
								"key=%h tag=%h occ=%0d, got st=%0b ev=%0b pv=%0b key=%h ",
								"tag=%h occ=%0d"}, $time, results_seen,
								want.stored, want.evicted, want.pop_valid, want.out_key,
								want.out_tag, want.occupancy, out_data.stored,
								out_data.evicted, out_data.pop_valid, out_data.out_key,
								out_data.out_tag, out_data.occupancy);
						mismatch_total++;
					end
				end
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_CAPACITY:  cap_now = cfg_wdata[CAP_W-1:0];
					CFG_THR_EN:    thr_on  = cfg_wdata[0];
					CFG_THRESHOLD: thr_key = cfg_wdata[KEY_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				due_results.push_back(apply_item(in_data));
		end
		waiting = due_results.size();
	end

endmodule

>>> verif/tb_top.sv
// testbench top: stimulus, flow control and verdict for the top-k queue
`timescale 1ns / 1ps
module tb_top;
	import btkq_pkg::*;

	// index with no register behind it, writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BACKLOG_HOLD   = 64;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	int fail_count;
	int pending;

	// knobs read by the sender or the receiver, written by the sender only
	int gap_pct = 0;
	int stall_pct = 0;
	bit calm = 1'b0;
	bit want_backlog = 1'b0;

	// threshold currently loaded, used to aim keys right at it
	logic signed [KEY_W-1:0] thr_now = '0;

	int inserts_sent = 0;
	int pops_sent = 0;
	int settings_used = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	bounded_top_k_queue_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	topk_queue_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// key mix: extremes, a cluster of small values with many ties, -1,
	// keys right around the threshold, and fully random keys
	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: pick_key = 32'sh7fff_ffff;
			1: pick_key = 32'sh8000_0000;
			2, 3, 4: pick_key = ($signed($urandom_range(0, 6)) - 3) * 65536;
			5: pick_key = -1;
			6: pick_key = thr_now + $signed($urandom_range(0, 2)) - 1;
			default: pick_key = $urandom;
		endcase
	endfunction

	// one input transfer, with an optional burst of idle cycles ahead of it;
	// entered and left at a falling edge
	task automatic send_item(input logic kind, input logic signed [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{kind: kind, entry_key: key, entry_tag: tag};
		// payload holds until the block takes it
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		if (kind == KIND_POP)
			pops_sent++;
		else
			inserts_sent++;
	endtask

	// stop offering and wait for every outstanding result to come back
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// loads all three registers; unused upper bits carry random junk
	task automatic configure(input logic [CAP_W-1:0] cap, input logic en,
			input logic signed [KEY_W-1:0] thr);
		logic [CFG_W-1:0] junk;
		junk = $urandom;
		write_reg(CFG_CAPACITY, {junk[CFG_W-1:CAP_W], cap});
		junk = $urandom;
		write_reg(CFG_THR_EN, {junk[CFG_W-1:1], en});
		write_reg(CFG_THRESHOLD, thr);
		thr_now = thr;
		settings_used++;
	endtask

	// random traffic; ins_pct sets the insert/pop mix and so how full the queue runs
	task automatic run_phase(input int n, input int ins_pct, input int gap, input int stall);
		gap_pct   = gap;
		stall_pct = stall;
		repeat (n) begin
			if ($urandom_range(0, 99) < ins_pct)
				send_item(KIND_INSERT, pick_key(), TAG_W'($urandom));
			else
				send_item(KIND_POP, KEY_W'($urandom), TAG_W'($urandom));
		end
		drain();
	endtask

	// receiver: random stall bursts, and one long hold whenever a backlog is asked for
	initial begin : receiver
		int  hold_left;
		bit  backlog_taken;
		hold_left     = 0;
		backlog_taken = 1'b0;
		out_stall     = 1'b0;
		forever begin
			@(negedge clk);
			if (!want_backlog)
				backlog_taken = 1'b0;
			if (hold_left == 0) begin
				if (want_backlog && !backlog_taken) begin
					hold_left     = BACKLOG_HOLD;
					backlog_taken = 1'b1;
				end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
					hold_left = $urandom_range(1, 9);
				end
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: too long without any transfer on either channel means a hang
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%t: no transfer for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, pending);
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, reset settings: capacity 32, no threshold
		gap_pct   = 20;
		stall_pct = 20;
		send_item(KIND_POP, 32'sh1234_5678, 16'habcd);  // pop on an empty queue
		send_item(KIND_INSERT, 32'sh7fff_ffff, 16'hffff);
		send_item(KIND_INSERT, 32'sh8000_0000, 16'h0000);
		send_item(KIND_INSERT, 32'sh0000_0000, 16'h0001);
		send_item(KIND_INSERT, 32'sh0000_0000, 16'h0002);  // tie, newest goes first
		repeat (5)
			send_item(KIND_POP, KEY_W'($urandom), TAG_W'($urandom));  // last one finds it empty
		drain();

		// capacity zero on an empty queue: nothing is stored
		write_reg(CFG_CAPACITY, '0);
		write_reg(CFG_UNUSED, '1);  // dropped, capacity stays zero
		send_item(KIND_INSERT, 32'sh0005_0000, 16'h0003);
		drain();

		// capacity two: replacement of the smallest, ties with it and below it
		write_reg(CFG_CAPACITY, 32'd2);
		send_item(KIND_INSERT, 32'sh0005_0000, 16'h0010);
		send_item(KIND_INSERT, 32'sh0003_0000, 16'h0011);
		send_item(KIND_INSERT, 32'sh0004_0000, 16'h0012);  // evicts 3.0
		send_item(KIND_INSERT, 32'sh0004_0000, 16'h0013);  // equal to smallest, dropped
		send_item(KIND_INSERT, 32'sh0001_0000, 16'h0014);  // below smallest, dropped
		drain();

		// threshold gate on a full queue
		write_reg(CFG_THR_EN, 32'd1);
		write_reg(CFG_THRESHOLD, 32'h000a_0000);
		thr_now = 32'sh000a_0000;
		send_item(KIND_INSERT, 32'sh0007_0000, 16'h0020);  // beats smallest, not threshold
		send_item(KIND_INSERT, 32'sh0014_0000, 16'h0021);  // beats both
		drain();

		// capacity below the fill: a replacement keeps the fill at two
		write_reg(CFG_CAPACITY, 32'd1);
		send_item(KIND_INSERT, 32'sh0064_0000, 16'h0030);
		repeat (3)
			send_item(KIND_POP, KEY_W'($urandom), TAG_W'($urandom));
		drain();
		settings_used += 4;

		// random part, one phase per register setting; each phase ends drained,
		// so the sender also pauses until every result is back
		configure(6'd63, 1'b0, '0);
		run_phase(200, 60, 25, 25);
		configure(6'd8, 1'b1, '0);
		run_phase(200, 75, 40, 10);
		configure(6'd0, 1'b0, '0);  // capacity zero, so the queue always counts as full
		run_phase(100, 70, 10, 40);
		configure(6'd33, 1'b1, 32'sh8000_0000);
		run_phase(200, 65, 25, 25);
		configure(6'd1, 1'b1, 32'sh7fff_ffff);  // threshold nothing can exceed
		run_phase(100, 60, 20, 20);

		// long receiver hold while the sender keeps offering: the block backs up
		configure(6'd3, 1'b0, $urandom);
		want_backlog = 1'b1;
		run_phase(150, 55, 0, 15);
		want_backlog = 1'b0;

		configure(6'd16, 1'b1, ($signed($urandom_range(0, 8)) - 4) * 65536);
		run_phase(200, 70, 30, 30);
		configure(6'd32, 1'b0, '0);
		run_phase(200, 55, 0, 0);  // back to back in both directions
		configure(6'd5, 1'b1, 32'shffff_0000);  // threshold at -1.0
		run_phase(200, 80, 15, 35);
		configure(6'd2, 1'b0, '0);
		run_phase(150, 60, 35, 15);
		configure(6'd31, 1'b1, $urandom);
		run_phase(150, 70, 20, 20);

		// tail of the run with no idling on either side
		calm = 1'b1;
		configure(6'd20, 1'b1, 32'sh0000_0000);
		run_phase(150, 50, 0, 0);

		repeat (4) @(negedge clk);
		$display("covered %0d inserts and %0d pops over %0d register settings,",
			inserts_sent, pops_sent, settings_used);
		$display("with stall bursts, one long receiver hold and a quiet tail");
		if (fail_count == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d failures, %0d results outstanding", fail_count, pending);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
